### sv/etfs_pkg.sv
// ----------------------------------------------------------------------------
// etfs_pkg
// Shared types, constants and saturation helper for the Euler transfer
// function simulator.
// ----------------------------------------------------------------------------
package etfs_pkg;

  localparam int ORDER     = 8;
  localparam int FRAC_BITS = 16;
  localparam int Q_W       = 32;
  localparam int IDX_W     = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam int ACC_W     = Q_W + 8;
  localparam int ORD_W     = 4;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [Q_W-1:0]   q_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [IDX_W-1:0]        idx_t;

  localparam logic CMD_EXCITE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER   = 3'd0,
    REG_STEP    = 3'd1,
    REG_GAIN    = 3'd2,
    REG_OUT_MIN = 3'd3,
    REG_OUT_MAX = 3'd4
  } reg_idx_t;

  localparam logic [ORD_W-1:0] ORDER_RST   = 4'd1;
  localparam q_t               STEP_RST    = 32'sd65536;
  localparam q_t               GAIN_RST    = 32'sd0;
  localparam q_t               OUT_MIN_RST = -32'sd6553600;
  localparam q_t               OUT_MAX_RST = 32'sd6553600;

  localparam logic signed [63:0] Q_HI = 64'sd2147483647;
  localparam logic signed [63:0] Q_LO = -64'sd2147483648;

  typedef struct packed {
    logic en;
    idx_t addr;
    q_t   fb;
    q_t   num;
  } coef_wr_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    q_t   data;
  } state_wr_t;

  function automatic q_t sat_q(input logic signed [63:0] v);
    q_t r;
    if (v > Q_HI) begin
      r = q_t'(Q_HI);
    end else if (v < Q_LO) begin
      r = q_t'(Q_LO);
    end else begin
      r = q_t'(v);
    end
    return r;
  endfunction

endpackage

### sv/etfs_mac.sv
// ----------------------------------------------------------------------------
// etfs_mac
// Shared fixed point multiplier: registered 64-bit product, then floor
// shift by the fraction width and saturation to the Q format.
// ----------------------------------------------------------------------------
module etfs_mac (
  input  logic          clk,
  input  etfs_pkg::q_t  op_a,
  input  etfs_pkg::q_t  op_b,
  output etfs_pkg::q_t  q
);
  import etfs_pkg::*;

  logic signed [63:0] prod;

  always_ff @(posedge clk) begin
    prod <= 64'(op_a) * 64'(op_b);
  end

  assign q = sat_q(prod >>> FRAC_BITS);

endmodule

### sv/etfs_store.sv
// ----------------------------------------------------------------------------
// etfs_store
// Coefficient tables and state vector memories with registered reads.
// State entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module etfs_store (
  input  logic                clk,
  input  logic                rst,
  input  etfs_pkg::coef_wr_t  coef_wr,
  input  etfs_pkg::idx_t      coef_raddr,
  output etfs_pkg::q_t        coef_fb,
  output etfs_pkg::q_t        coef_num,
  input  etfs_pkg::state_wr_t st_wr,
  input  etfs_pkg::idx_t      st_raddr,
  output etfs_pkg::q_t        st_rdata
);
  import etfs_pkg::*;

  q_t               fb_mem  [ORDER];
  q_t               num_mem [ORDER];
  q_t               st_mem  [ORDER];
  logic [ORDER-1:0] st_valid;
  q_t               st_q;
  logic             st_q_valid;

  always_ff @(posedge clk) begin
    if (coef_wr.en) begin
      fb_mem[coef_wr.addr]  <= coef_wr.fb;
      num_mem[coef_wr.addr] <= coef_wr.num;
    end
    coef_fb  <= fb_mem[coef_raddr];
    coef_num <= num_mem[coef_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_wr.en) begin
      st_mem[st_wr.addr] <= st_wr.data;
    end
    st_q <= st_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid   <= '0;
      st_q_valid <= 1'b0;
    end else begin
      if (st_wr.en) begin
        st_valid[st_wr.addr] <= 1'b1;
      end
      st_q_valid <= st_valid[st_raddr];
    end
  end

  assign st_rdata = st_q_valid ? st_q : '0;

endmodule

### sv/euler_transfer_function_sim_core.sv
// ----------------------------------------------------------------------------
// euler_transfer_function_sim_core
// Forward Euler simulation of a transfer function in canonical state form.
// One item at a time: s_axis_tready is high only in S_IDLE, so the next
// item is taken only after the last has been passed to the output in
// S_OUT, which waits on output back-pressure; an excite walks the state
// memory with the single shared multiplier.
// Reset: synchronous; state vector reads zero, registers to defaults.
// ----------------------------------------------------------------------------
module euler_transfer_function_sim_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // coef_index, excitation, feedback_coef,
                                      // numerator_coef
  input  logic [0:0]   s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,  // output_value
  output logic [0:0]   m_axis_tuser   // saturated
);
  import etfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_COEF, S_FEED, S_FACC, S_DIFF, S_STATE,
    S_CMUL, S_YACC, S_DGAIN, S_DSUM, S_CLAMP, S_OUT
  } fsm_t;

  fsm_t             state;
  logic [ORD_W-1:0] order_in_use;
  q_t               step_size;
  q_t               direct_gain;
  q_t               out_min;
  q_t               out_max;

  idx_t k;
  idx_t kstart;
  q_t   u;
  q_t   fb;
  q_t   nm;
  q_t   xcur;
  q_t   xlow;
  q_t   c;
  q_t   xnew;
  acc_t facc;
  acc_t yacc;
  q_t   yfin;
  logic satfin;

  logic [2:0] in_idx;
  q_t         in_u;
  q_t         in_fb;
  q_t         in_nm;
  logic       in_cmd;
  logic       in_xfer;

  coef_wr_t  coef_wr;
  state_wr_t st_wr;
  idx_t      coef_raddr;
  idx_t      st_raddr;
  q_t        coef_fb;
  q_t        coef_num;
  q_t        st_rdata;
  q_t        op_a;
  q_t        op_b;
  q_t        q;
  q_t        x_upd;
  acc_t      lo;
  acc_t      hi;
  acc_t      y1;
  acc_t      y2;
  logic      s1;
  logic      s2;

  assign in_idx  = s_axis_tdata[2:0];
  assign in_u    = q_t'(s_axis_tdata[34:3]);
  assign in_fb   = q_t'(s_axis_tdata[66:35]);
  assign in_nm   = q_t'(s_axis_tdata[98:67]);
  assign in_cmd  = s_axis_tuser[0];
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    if (order_in_use == '0) begin
      kstart = '0;
    end else if (int'(order_in_use) > ORDER) begin
      kstart = IDX_W'(ORDER - 1);
    end else begin
      kstart = IDX_W'(order_in_use - 4'd1);
    end
  end

  always_comb begin
    coef_raddr = k;
    st_raddr   = k - IDX_W'(1);
    if (state == S_IDLE) begin
      coef_raddr = kstart;
      st_raddr   = kstart;
    end else if (state == S_YACC) begin
      coef_raddr = k - IDX_W'(1);
      st_raddr   = k - IDX_W'(2);
    end
  end

  assign coef_wr.en   = in_xfer && (in_cmd == CMD_LOAD) && (int'(in_idx) < ORDER);
  assign coef_wr.addr = IDX_W'(in_idx);
  assign coef_wr.fb   = in_fb;
  assign coef_wr.num  = in_nm;

  assign x_upd       = sat_q(64'(xcur) + 64'(q));
  assign st_wr.en    = (state == S_STATE);
  assign st_wr.addr  = k;
  assign st_wr.data  = x_upd;

  always_comb begin
    unique case (state)
      S_COEF:  begin op_a = coef_fb;           op_b = direct_gain; end
      S_FEED:  begin op_a = fb;                op_b = xcur;        end
      S_FACC:  begin op_a = xlow;              op_b = step_size;   end
      S_DIFF:  begin op_a = sat_q(64'(facc));  op_b = step_size;   end
      S_CMUL:  begin op_a = c;                 op_b = xnew;        end
      S_DGAIN: begin op_a = direct_gain;       op_b = u;           end
      default: begin op_a = fb;                op_b = xcur;        end
    endcase
  end

  always_comb begin
    lo = ACC_W'(out_min);
    hi = ACC_W'(out_max);
    s1 = (yacc < lo);
    y1 = s1 ? lo : yacc;
    s2 = (y1 > hi);
    y2 = s2 ? hi : y1;
  end

  etfs_store u_store (
    .clk        (clk),
    .rst        (rst),
    .coef_wr    (coef_wr),
    .coef_raddr (coef_raddr),
    .coef_fb    (coef_fb),
    .coef_num   (coef_num),
    .st_wr      (st_wr),
    .st_raddr   (st_raddr),
    .st_rdata   (st_rdata)
  );

  etfs_mac u_mac (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .q    (q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      order_in_use <= ORDER_RST;
      step_size    <= STEP_RST;
      direct_gain  <= GAIN_RST;
      out_min      <= OUT_MIN_RST;
      out_max      <= OUT_MAX_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ORDER:   order_in_use <= cfg_data[ORD_W-1:0];
        REG_STEP:    step_size    <= q_t'(cfg_data);
        REG_GAIN:    direct_gain  <= q_t'(cfg_data);
        REG_OUT_MIN: out_min      <= q_t'(cfg_data);
        REG_OUT_MAX: out_max      <= q_t'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_OUT)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            u    <= in_u;
            k    <= kstart;
            facc <= ACC_W'(in_u);
            yacc <= '0;
            if (in_cmd == CMD_LOAD) begin
              yfin   <= '0;
              satfin <= 1'b0;
              state  <= S_OUT;
            end else begin
              state <= S_PRE;
            end
          end
        end
        S_PRE: begin
          xcur  <= st_rdata;
          state <= S_COEF;
        end
        S_COEF: begin
          fb    <= coef_fb;
          nm    <= coef_num;
          xlow  <= st_rdata;
          state <= S_FEED;
        end
        S_FEED: begin
          c     <= sat_q(64'(nm) - 64'(q));
          state <= S_FACC;
        end
        S_FACC: begin
          facc  <= facc - ACC_W'(q);
          state <= (k == '0) ? S_DIFF : S_STATE;
        end
        S_DIFF: begin
          state <= S_STATE;
        end
        S_STATE: begin
          xnew  <= x_upd;
          state <= S_CMUL;
        end
        S_CMUL: begin
          state <= S_YACC;
        end
        S_YACC: begin
          yacc <= yacc + ACC_W'(q);
          if (k == '0) begin
            state <= S_DGAIN;
          end else begin
            xcur  <= xlow;
            k     <= k - IDX_W'(1);
            state <= S_COEF;
          end
        end
        S_DGAIN: begin
          state <= S_DSUM;
        end
        S_DSUM: begin
          yacc  <= yacc + ACC_W'(q);
          state <= S_CLAMP;
        end
        S_CLAMP: begin
          yfin   <= q_t'(y2);
          satfin <= s1 || s2;
          state  <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid   <= 1'b1;
            m_axis_tdata    <= yfin;
            m_axis_tuser[0] <= satfin;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_euler_transfer_function_sim_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_transfer_function_sim_core
// Self-checking bench for the Euler transfer function simulator. Coefficient
// loads and input samples go in over the input stream. Each transfer is
// mirrored in a scoreboard that steps its own copy of the state vector in
// Q16.16. Every output transfer is compared with the oldest prediction.
// Register settings change between phases, once the block has drained.
// Both stream sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_euler_transfer_function_sim_core;
  import etfs_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  class tf_output_scoreboard;
    longint      x[ORDER];
    longint      a_tab[ORDER];
    longint      b_tab[ORDER];
    int unsigned n_states_cfg;
    longint      dt;
    longint      b0;
    longint      y_lo;
    longint      y_hi;
    logic [32:0] pending_outputs[$];  // {saturated, output_value}
    int unsigned errors;
    int unsigned n_excite;
    int unsigned n_load;
    int unsigned n_clamped;

    function new();
      foreach (x[i]) begin
        x[i]     = 0;
        a_tab[i] = 0;
        b_tab[i] = 0;
      end
      n_states_cfg = ORDER_RST;
      dt           = STEP_RST;
      b0           = GAIN_RST;
      y_lo         = OUT_MIN_RST;
      y_hi         = OUT_MAX_RST;
      errors       = 0;
      n_excite     = 0;
      n_load       = 0;
      n_clamped    = 0;
    endfunction

    function void set_reg(reg_idx_t r, logic [31:0] v);
      case (r)
        REG_ORDER:   n_states_cfg = v[ORD_W-1:0];
        REG_STEP:    dt = q_t'(v);
        REG_GAIN:    b0 = q_t'(v);
        REG_OUT_MIN: y_lo = q_t'(v);
        REG_OUT_MAX: y_hi = q_t'(v);
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > Q_HI) return Q_HI;
      if (v < Q_LO) return Q_LO;
      return v;
    endfunction

    // floor of the Q16.16 product, saturated
    function longint qmul(longint p_a, longint p_b);
      longint p;
      p = p_a * p_b;
      return sat32(p >>> FRAC_BITS);
    endfunction

    function void note_item(logic cmd, logic [2:0] idx, q_t u, q_t fb, q_t num);
      longint fsum;
      longint y;
      longint d;
      longint c;
      longint uu;
      int     m;
      logic   sat;
      if (cmd == CMD_LOAD) begin
        a_tab[idx] = fb;
        b_tab[idx] = num;
        n_load++;
        pending_outputs.push_back(33'd0);
        return;
      end
      m = n_states_cfg;
      if (m < 1) m = 1;
      if (m > ORDER) m = ORDER;
      uu   = u;
      fsum = 0;
      y    = 0;
      // top state down, so each state sees the old value below it
      for (int i = m - 1; i >= 1; i--) begin
        fsum += qmul(a_tab[i], x[i]);
        x[i] = sat32(x[i] + qmul(x[i-1], dt));
        c = sat32(b_tab[i] - qmul(a_tab[i], b0));
        y += qmul(c, x[i]);
      end
      fsum += qmul(a_tab[0], x[0]);
      d = sat32(uu - fsum);
      x[0] = sat32(x[0] + qmul(d, dt));
      c = sat32(b_tab[0] - qmul(a_tab[0], b0));
      y += qmul(c, x[0]);
      y += qmul(b0, uu);
      sat = 1'b0;
      // lower clamp first, so out_max wins when the limits cross
      if (y < y_lo) begin
        y   = y_lo;
        sat = 1'b1;
      end
      if (y > y_hi) begin
        y   = y_hi;
        sat = 1'b1;
      end
      if (sat) n_clamped++;
      n_excite++;
      pending_outputs.push_back({sat, y[31:0]});
    endfunction

    function void check_output(logic [31:0] val, logic sat);
      logic [32:0] exp_w;
      if (pending_outputs.size() == 0) begin
        $display("%0t: output transfer with nothing pending: value=%h saturated=%0b",
                 $time, val, sat);
        errors++;
        return;
      end
      exp_w = pending_outputs.pop_front();
      if (val !== exp_w[31:0]) begin
        $display("%0t: output_value mismatch: expected %h, actual %h",
                 $time, exp_w[31:0], val);
        errors++;
      end
      if (sat !== exp_w[32]) begin
        $display("%0t: saturated mismatch: expected %0b, actual %0b",
                 $time, exp_w[32], sat);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // coef_index, excitation, feedback_coef,
                                    // numerator_coef
  logic [0:0]   s_axis_tuser = '0;  // cmd
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;       // output_value
  logic [0:0]   m_axis_tuser;       // saturated

  tf_output_scoreboard sb;
  bit                  tx_idle = 1'b0;
  bit                  rx_idle = 1'b0;
  int unsigned         n_settings = 0;

  euler_transfer_function_sim_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic q_t small_q(int span);
    return q_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic q_t pick_value();
    q_t r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: r = 32'h7fff_ffff;
          1: r = 32'h8000_0000;
          2: r = '0;
          default: r = '1;
        endcase
      end
      1, 2, 3: r = $urandom;
      default: r = small_q(131072);
    endcase
    return r;
  endfunction

  // write enable stays high across back-to-back writes; end_reg_writes drops it
  task automatic write_reg(reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    sb.set_reg(r, v);
  endtask

  task automatic end_reg_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(logic [3:0] order, q_t step, q_t gain, q_t lo, q_t hi);
    write_reg(REG_ORDER, {28'd0, order});
    write_reg(REG_STEP, step);
    write_reg(REG_GAIN, gain);
    write_reg(REG_OUT_MIN, lo);
    write_reg(REG_OUT_MAX, hi);
    end_reg_writes();
    n_settings++;
  endtask

  task automatic send_item(logic cmd, logic [2:0] idx, q_t u, q_t fb, q_t num);
    int gap;
    gap = pick_gap(tx_idle);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, num, fb, u, idx};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(cmd, idx, u, fb, num);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_outputs.size() != 0);
  endtask

  task automatic load_table();
    for (int i = 0; i < ORDER; i++) begin
      send_item(CMD_LOAD, 3'(i), $urandom, small_q(32768), small_q(131072));
    end
  endtask

  task automatic random_settings();
    logic [3:0] order;
    q_t         step;
    q_t         gain;
    q_t         lo;
    q_t         hi;
    q_t         tmp;
    order = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 8));
    case ($urandom_range(0, 9))
      0: step = '0;
      1: step = -q_t'($urandom_range(1, 65536));
      2: step = $urandom;
      default: step = $urandom_range(512, 32768);
    endcase
    gain = ($urandom_range(0, 7) == 0) ? q_t'($urandom) : small_q(131072);
    lo   = -q_t'($urandom_range(0, 13107200));
    hi   = $urandom_range(0, 13107200);
    case ($urandom_range(0, 7))
      0: begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      1: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      default: ;
    endcase
    apply_settings(order, step, gain, lo, hi);
  endtask

  task automatic random_item();
    logic       cmd;
    logic [2:0] idx;
    q_t         u;
    q_t         fb;
    q_t         num;
    cmd = ($urandom_range(0, 9) == 0) ? CMD_LOAD : CMD_EXCITE;
    idx = $urandom_range(0, 7);
    u   = ($urandom_range(0, 1) == 0) ? small_q(6553600) : pick_value();
    if (cmd == CMD_LOAD && $urandom_range(0, 9) < 7) begin
      fb  = small_q(32768);
      num = small_q(131072);
    end else begin
      fb  = pick_value();
      num = pick_value();
    end
    send_item(cmd, idx, u, fb, num);
  endtask

  // output side: check each transfer, stall at random
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        sb.check_output(m_axis_tdata, m_axis_tuser[0]);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (rx_idle && $urandom_range(0, 7) == 0) stall_left = pick_gap(1'b1);
        m_axis_tready <= (stall_left == 0);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", CYCLE_LIMIT);
    $display("tb_euler_transfer_function_sim_core failed");
    $finish;
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default settings; fill every table entry before any excite
    send_item(CMD_LOAD, 3'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    for (int i = 1; i < ORDER - 1; i++) begin
      send_item(CMD_LOAD, 3'(i), '0, small_q(32768), small_q(131072));
    end
    send_item(CMD_LOAD, 3'd7, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CMD_EXCITE, 3'd7, 32'h7fff_ffff, '1, '1);
    send_item(CMD_EXCITE, 3'd0, 32'h8000_0000, '0, '0);
    send_item(CMD_EXCITE, 3'd5, '0, '1, '0);
    send_item(CMD_EXCITE, 3'd2, 32'sd65536, '0, '1);
    wait_for_drain();

    // order above range, negative step, crossed limits
    apply_settings(4'd15, -32'sd65536, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_item(CMD_EXCITE, 3'd0, 32'sd6553600, '0, '0);
    send_item(CMD_EXCITE, 3'd0, -32'sd6553600, '0, '0);
    send_item(CMD_EXCITE, 3'd0, 32'h8000_0000, '0, '0);
    wait_for_drain();

    // order zero, zero step, full-range limits
    apply_settings(4'd0, '0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(CMD_EXCITE, 3'd0, 32'h7fff_ffff, '0, '0);
    send_item(CMD_EXCITE, 3'd0, 32'sd131072, '0, '0);
    wait_for_drain();

    // full order, largest step
    apply_settings(4'd8, 32'h7fff_ffff, 32'sd65536, OUT_MIN_RST, OUT_MAX_RST);
    send_item(CMD_EXCITE, 3'd0, 32'h7fff_ffff, '0, '0);
    send_item(CMD_EXCITE, 3'd0, 32'h8000_0000, '0, '0);
    send_item(CMD_LOAD, 3'd3, '0, 32'sd16384, -32'sd65536);
    send_item(CMD_EXCITE, 3'd0, 32'sd65536, '0, '0);
    wait_for_drain();

    for (int p = 0; p < PHASES; p++) begin
      tx_idle = (p % 3 != 0);
      rx_idle = (p % 4 != 1);
      random_settings();
      load_table();
      for (int n = ORDER; n < PHASE_ITEMS; n++) random_item();
      wait_for_drain();
    end

    repeat (6 * ORDER + 6) @(posedge clk);
    $display("covered %0d excite and %0d load transfers over %0d register settings",
             sb.n_excite, sb.n_load, n_settings);
    $display("%0d outputs clamped, %0d mismatches", sb.n_clamped, sb.errors);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("tb_euler_transfer_function_sim_core passed");
    end else begin
      $display("tb_euler_transfer_function_sim_core failed");
    end
    $finish;
  end

endmodule
